// ===== src/mqdf_pkg.sv =====
// package for the multi-queue descriptor fifo
// opcode, response and state types, field widths and parameter defaults
// no dependencies
package mqdf_pkg;

	localparam int NUM_QUEUES_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int OPCODE_W = 2;
	localparam int QSEL_W   = 4;
	localparam int CONN_W   = 8;
	localparam int HANDLE_W = 32;
	localparam int LEN_W    = 16;
	localparam int DESC_W   = CONN_W + HANDLE_W + LEN_W;
	localparam int FILL_W   = 5;
	localparam int STATUS_W = 3;

	localparam int HANDLE_LSB = CONN_W;

	localparam int S_TUSER_W = OPCODE_W + QSEL_W + 1;
	localparam int S_TDATA_W = DESC_W;
	localparam int M_TUSER_W = STATUS_W + 1;
	localparam int M_TDATA_W = 64;
	localparam int M_PAD_W   = M_TDATA_W - FILL_W - DESC_W;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		RSP_PUT_OK     = 3'd0,
		RSP_PUT_FULL   = 3'd1,
		RSP_GET_OK     = 3'd2,
		RSP_GET_EMPTY  = 3'd3,
		RSP_DRAINED    = 3'd4,
		RSP_CLEAR_DONE = 3'd5
	} resp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_GET_DATA,
		S_EMIT,
		S_CLR_DATA,
		S_CLR_DONE
	} fsm_t;

endpackage

// ===== src/mqdf_ram.sv =====
// generic simple dual-port ram with one write port and a registered read port
// no dependencies
module mqdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/multi_queue_descriptor_fifo_core.sv =====
// top level of the multi-queue descriptor fifo: control sequencer and ram instances
// depends on mqdf_pkg and mqdf_ram
//
// Usage: a request enters on the s_axis channel (tuser carries opcode, queue and
// entry kind, tdata carries the descriptor). Put and get answer with one result,
// clear answers with one result per drained data descriptor with a nonzero handle,
// then a done result with tlast high. Results leave on the m_axis channel.
// Slot contents sit in two rams (kind and descriptor), queue head, tail and count
// in a third ram indexed by queue, with a valid flop per queue so that a queue
// never written reads as empty; there is no clearing pass after reset.
// A put passes the pointer ram read, the result register and the output register;
// a get adds the slot ram read ahead of the result register, and a clear gives its
// done result after the walk over the stored entries. One request is worked on at
// a time; the next request is taken when the sequencer is back idle. A clear walks
// the queue one slot read per cycle while no drained result waits on a stalled receiver.
// A result waiting in the output register does not block a new request; when the
// receiver stalls, the sequencer holds in its result state until the register
// frees. Reset empties all queues and drops any pending result.
module multi_queue_descriptor_fifo_core #(
	parameter int NUM_QUEUES  = mqdf_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = mqdf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// conn_id, buffer_handle, msg_length
	input  logic [mqdf_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// opcode, queue_sel, entry_kind
	input  logic [mqdf_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_conn_id, out_handle, out_length, fill_count, zero pad
	output logic [mqdf_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status, out_kind
	output logic [mqdf_pkg::M_TUSER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast
);

	localparam int QW     = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
	localparam int PW     = $clog2(QUEUE_DEPTH);
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W  = CW + 2 * PW;
	localparam int SLOT_D = 1 << (QW + PW);
	localparam int DW     = mqdf_pkg::DESC_W;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
		return r;
	endfunction

	mqdf_pkg::fsm_t state_q, state_nxt;

	logic [QW-1:0] qmod_tab [2**mqdf_pkg::QSEL_W];
	for (genvar i = 0; i < 2**mqdf_pkg::QSEL_W; i++) begin : g_qmod
		assign qmod_tab[i] = QW'(i % NUM_QUEUES);
	end

	mqdf_pkg::opcode_t in_op;
	logic              in_acc;
	logic [QW-1:0]     in_q;

	mqdf_pkg::opcode_t op_q;
	logic [QW-1:0]     q_q;
	logic              kind_q;
	logic [DW-1:0]     desc_q;
	logic [PW-1:0]     head_q;
	logic [CW-1:0]     cnt_q;
	logic [NUM_QUEUES-1:0] qvld_q;

	mqdf_pkg::resp_t res_status_q;
	logic            res_kind_q;
	logic [DW-1:0]   res_desc_q;
	logic [CW-1:0]   res_fill_q;

	logic                    out_valid_q;
	mqdf_pkg::resp_t         out_status_q;
	logic                    out_kind_q;
	logic [DW-1:0]           out_desc_q;
	logic [mqdf_pkg::FILL_W-1:0] out_fill_q;
	logic                    out_last_q;

	logic             ptr_we;
	logic [PTR_W-1:0] ptr_wdata;
	logic [PTR_W-1:0] ptr_rdata;
	logic [PTR_W-1:0] ptr_word;
	logic [PW-1:0]    lk_head;
	logic [PW-1:0]    lk_tail;
	logic [CW-1:0]    lk_cnt;

	logic             kind_we;
	logic             desc_we;
	logic [QW+PW-1:0] slot_waddr;
	logic             slot_re;
	logic [QW+PW-1:0] slot_raddr;
	logic             kind_rdata;
	logic [DW-1:0]    desc_rdata;

	logic            out_free;
	logic            clr_emit;
	logic            clr_go;
	logic            ctr_load;
	logic [PW-1:0]   head_nxt;
	logic [CW-1:0]   cnt_nxt;

	logic            res_load;
	mqdf_pkg::resp_t res_status_nxt;
	logic            res_kind_nxt;
	logic [DW-1:0]   res_desc_nxt;
	logic [CW-1:0]   res_fill_nxt;

	logic            out_load;
	mqdf_pkg::resp_t out_status_nxt;
	logic            out_kind_nxt;
	logic [DW-1:0]   out_desc_nxt;
	logic [CW-1:0]   out_fill_nxt;
	logic            out_last_nxt;

	assign in_op         = mqdf_pkg::opcode_t'(s_axis_tuser[mqdf_pkg::OPCODE_W-1:0]);
	assign in_q          = qmod_tab[s_axis_tuser[mqdf_pkg::OPCODE_W +: mqdf_pkg::QSEL_W]];
	assign s_axis_tready = (state_q == mqdf_pkg::S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// a queue never written reads as empty
	assign ptr_word = qvld_q[q_q] ? ptr_rdata : '0;
	assign lk_head  = ptr_word[PW-1:0];
	assign lk_tail  = ptr_word[2*PW-1:PW];
	assign lk_cnt   = ptr_word[PTR_W-1:2*PW];

	assign out_free = !out_valid_q || m_axis_tready;
	assign clr_emit = !kind_rdata
		&& (desc_rdata[mqdf_pkg::HANDLE_LSB +: mqdf_pkg::HANDLE_W] != '0);
	assign clr_go   = !clr_emit || out_free;

	mqdf_ram #(.WIDTH(PTR_W), .DEPTH(NUM_QUEUES)) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (q_q),
		.wdata (ptr_wdata),
		.re    (in_acc),
		.raddr (in_q),
		.rdata (ptr_rdata)
	);

	mqdf_ram #(.WIDTH(1), .DEPTH(SLOT_D)) u_kind_ram (
		.clk   (clk),
		.we    (kind_we),
		.waddr (slot_waddr),
		.wdata (kind_q),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (kind_rdata)
	);

	mqdf_ram #(.WIDTH(DW), .DEPTH(SLOT_D)) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (slot_waddr),
		.wdata (desc_q),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (desc_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mqdf_pkg::S_IDLE: begin
				if (in_acc && in_op != mqdf_pkg::OP_NONE) begin
					state_nxt = mqdf_pkg::S_LOOKUP;
				end
			end
			mqdf_pkg::S_LOOKUP: begin
				case (op_q)
					mqdf_pkg::OP_PUT: begin
						state_nxt = mqdf_pkg::S_EMIT;
					end
					mqdf_pkg::OP_GET: begin
						state_nxt = (lk_cnt == '0) ? mqdf_pkg::S_EMIT : mqdf_pkg::S_GET_DATA;
					end
					mqdf_pkg::OP_CLEAR: begin
						state_nxt = (lk_cnt == '0) ? mqdf_pkg::S_CLR_DONE : mqdf_pkg::S_CLR_DATA;
					end
					default: begin
						state_nxt = mqdf_pkg::S_IDLE;
					end
				endcase
			end
			mqdf_pkg::S_GET_DATA: begin
				state_nxt = mqdf_pkg::S_EMIT;
			end
			mqdf_pkg::S_EMIT: begin
				if (out_free) begin
					state_nxt = mqdf_pkg::S_IDLE;
				end
			end
			mqdf_pkg::S_CLR_DATA: begin
				if (clr_go && cnt_q == '0) begin
					state_nxt = mqdf_pkg::S_CLR_DONE;
				end
			end
			mqdf_pkg::S_CLR_DONE: begin
				if (out_free) begin
					state_nxt = mqdf_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = mqdf_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ptr_we         = 1'b0;
		ptr_wdata      = '0;
		kind_we        = 1'b0;
		desc_we        = 1'b0;
		slot_waddr     = {q_q, lk_tail};
		slot_re        = 1'b0;
		slot_raddr     = {q_q, head_q};
		ctr_load       = 1'b0;
		head_nxt       = head_q;
		cnt_nxt        = cnt_q;
		res_load       = 1'b0;
		res_status_nxt = mqdf_pkg::RSP_PUT_OK;
		res_kind_nxt   = 1'b0;
		res_desc_nxt   = '0;
		res_fill_nxt   = '0;
		out_load       = 1'b0;
		out_status_nxt = res_status_q;
		out_kind_nxt   = res_kind_q;
		out_desc_nxt   = res_desc_q;
		out_fill_nxt   = res_fill_q;
		out_last_nxt   = 1'b1;
		case (state_q)
			mqdf_pkg::S_LOOKUP: begin
				case (op_q)
					mqdf_pkg::OP_PUT: begin
						res_load = 1'b1;
						if (lk_cnt == CW'(QUEUE_DEPTH)) begin
							res_status_nxt = mqdf_pkg::RSP_PUT_FULL;
							res_fill_nxt   = lk_cnt;
						end else begin
							kind_we        = 1'b1;
							desc_we        = !kind_q;
							ptr_we         = 1'b1;
							ptr_wdata      = {lk_cnt + CW'(1), ptr_inc(lk_tail), lk_head};
							res_status_nxt = mqdf_pkg::RSP_PUT_OK;
							res_fill_nxt   = lk_cnt + CW'(1);
						end
					end
					mqdf_pkg::OP_GET: begin
						if (lk_cnt == '0) begin
							res_load       = 1'b1;
							res_status_nxt = mqdf_pkg::RSP_GET_EMPTY;
						end else begin
							slot_re    = 1'b1;
							slot_raddr = {q_q, lk_head};
							ptr_we     = 1'b1;
							ptr_wdata  = {lk_cnt - CW'(1), lk_tail, ptr_inc(lk_head)};
							ctr_load   = 1'b1;
							head_nxt   = ptr_inc(lk_head);
							cnt_nxt    = lk_cnt - CW'(1);
						end
					end
					mqdf_pkg::OP_CLEAR: begin
						ctr_load = 1'b1;
						head_nxt = lk_head;
						cnt_nxt  = lk_cnt;
						if (lk_cnt != '0) begin
							slot_re    = 1'b1;
							slot_raddr = {q_q, lk_head};
							head_nxt   = ptr_inc(lk_head);
							cnt_nxt    = lk_cnt - CW'(1);
						end
					end
					default: begin
						res_load = 1'b0;
					end
				endcase
			end
			mqdf_pkg::S_GET_DATA: begin
				res_load       = 1'b1;
				res_status_nxt = mqdf_pkg::RSP_GET_OK;
				res_kind_nxt   = kind_rdata;
				res_desc_nxt   = kind_rdata ? '0 : desc_rdata;
				res_fill_nxt   = cnt_q;
			end
			mqdf_pkg::S_EMIT: begin
				out_load = out_free;
			end
			mqdf_pkg::S_CLR_DATA: begin
				out_load       = clr_emit && out_free;
				out_status_nxt = mqdf_pkg::RSP_DRAINED;
				out_kind_nxt   = 1'b0;
				out_desc_nxt   = desc_rdata;
				out_fill_nxt   = cnt_q;
				out_last_nxt   = 1'b0;
				if (clr_go && cnt_q != '0) begin
					slot_re  = 1'b1;
					ctr_load = 1'b1;
					head_nxt = ptr_inc(head_q);
					cnt_nxt  = cnt_q - CW'(1);
				end
			end
			mqdf_pkg::S_CLR_DONE: begin
				ptr_we         = 1'b1;
				ptr_wdata      = '0;
				out_load       = out_free;
				out_status_nxt = mqdf_pkg::RSP_CLEAR_DONE;
				out_kind_nxt   = 1'b0;
				out_desc_nxt   = '0;
				out_fill_nxt   = '0;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mqdf_pkg::S_IDLE;
			qvld_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ptr_we) begin
				qvld_q[q_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in_op;
			q_q    <= in_q;
			kind_q <= s_axis_tuser[mqdf_pkg::OPCODE_W + mqdf_pkg::QSEL_W];
			desc_q <= s_axis_tdata;
		end
		if (ctr_load) begin
			head_q <= head_nxt;
			cnt_q  <= cnt_nxt;
		end
		if (res_load) begin
			res_status_q <= res_status_nxt;
			res_kind_q   <= res_kind_nxt;
			res_desc_q   <= res_desc_nxt;
			res_fill_q   <= res_fill_nxt;
		end
		if (out_load) begin
			out_status_q <= out_status_nxt;
			out_kind_q   <= out_kind_nxt;
			out_desc_q   <= out_desc_nxt;
			out_fill_q   <= mqdf_pkg::FILL_W'(out_fill_nxt);
			out_last_q   <= out_last_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{mqdf_pkg::M_PAD_W{1'b0}}, out_fill_q, out_desc_q};
	assign m_axis_tuser  = {out_kind_q, out_status_q};
	assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// a result that is not the last of its request is always a drained entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:0] == mqdf_pkg::RSP_DRAINED))
		else $error("non-final result with wrong status");

	// pointer write-back never stores a count above the queue depth
	assert property (@(posedge clk) disable iff (!arst_n)
		ptr_we |-> (ptr_wdata[PTR_W-1:2*PW] <= CW'(QUEUE_DEPTH)))
		else $error("queue count overflow");

	// slot writes only happen for a put in the lookup step
	assert property (@(posedge clk) disable iff (!arst_n)
		(kind_we || desc_we) |-> (state_q == mqdf_pkg::S_LOOKUP && op_q == mqdf_pkg::OP_PUT))
		else $error("slot write outside put");

	// the lookup step always follows an accepted request
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mqdf_pkg::S_LOOKUP) |-> $past(in_acc))
		else $error("lookup without request");

	// the drain walk has emptied the queue before done
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mqdf_pkg::S_CLR_DONE) |-> (cnt_q == '0))
		else $error("clear done with entries left");
`endif

endmodule
